### sv/lgi_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the four-point lagrange interpolator
package lgi_pkg;

    localparam int DATA_W = 16;
    localparam int DIFF_W = DATA_W + 1;
    localparam int PROD_W = 2 * DATA_W;
    localparam int P_W    = 4 * DATA_W;
    localparam int DM_W   = 3 * DATA_W;
    localparam int NUM_W  = P_W + 8;
    localparam int QUO_W  = 41;
    localparam int REM_W  = DM_W;
    localparam int TERM_W = QUO_W + 1;
    localparam int SUM_W  = TERM_W + 2;
    localparam int OUT_W  = 32;
    localparam int IDX_W  = 3;

    localparam logic [TERM_W-1:0] TERM_CAP = {2'b01, {(TERM_W-2){1'b0}}};

    localparam logic [IDX_W-1:0] REG_NODE_X0 = 3'd0;
    localparam logic [IDX_W-1:0] REG_NODE_X1 = 3'd1;
    localparam logic [IDX_W-1:0] REG_NODE_X2 = 3'd2;
    localparam logic [IDX_W-1:0] REG_NODE_X3 = 3'd3;
    localparam logic [IDX_W-1:0] REG_NODE_Y0 = 3'd4;
    localparam logic [IDX_W-1:0] REG_NODE_Y1 = 3'd5;
    localparam logic [IDX_W-1:0] REG_NODE_Y2 = 3'd6;
    localparam logic [IDX_W-1:0] REG_NODE_Y3 = 3'd7;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] low;
        logic [QUO_W-1:0] quo;
        logic [REM_W-1:0] dvs;
        logic             ovf;
        logic             neg;
    } div_t;

endpackage

### sv/lgi_cell.sv
`timescale 1ns / 1ps
// one restoring division cell: yields one quotient bit per cell
module lgi_cell
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          valid_in,
    input  lgi_pkg::div_t data_in,
    output logic          valid_out,
    output lgi_pkg::div_t data_out
);

    logic          valid_reg;
    lgi_pkg::div_t data_reg;
    lgi_pkg::div_t data_next;
    logic [lgi_pkg::REM_W:0] trial;
    logic [lgi_pkg::REM_W:0] diff;

    always_comb
    begin
        trial = {data_in.rem, data_in.low[lgi_pkg::QUO_W-1]};
        diff = trial - {1'b0, data_in.dvs};
        data_next = data_in;
        data_next.low = {data_in.low[lgi_pkg::QUO_W-2:0], 1'b0};
        if (trial >= {1'b0, data_in.dvs})
        begin
            data_next.rem = diff[lgi_pkg::REM_W-1:0];
            data_next.quo = {data_in.quo[lgi_pkg::QUO_W-2:0], 1'b1};
        end
        else
        begin
            data_next.rem = trial[lgi_pkg::REM_W-1:0];
            data_next.quo = {data_in.quo[lgi_pkg::QUO_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

### sv/lgi_term.sv
`timescale 1ns / 1ps
// one basis term: difference products, divider cell chain, rounding and cap
module lgi_term
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                valid_in,
    input  logic signed [lgi_pkg::DATA_W-1:0]   query_x,
    input  logic signed [lgi_pkg::DATA_W-1:0]   xi,
    input  logic signed [lgi_pkg::DATA_W-1:0]   xa,
    input  logic signed [lgi_pkg::DATA_W-1:0]   xb,
    input  logic signed [lgi_pkg::DATA_W-1:0]   xc,
    input  logic signed [lgi_pkg::DATA_W-1:0]   yi,
    output logic                                valid_out,
    output logic signed [lgi_pkg::TERM_W-1:0]   term,
    output logic                                capped
);

    localparam int DW = lgi_pkg::DATA_W;
    localparam int DIFF_W = lgi_pkg::DIFF_W;

    // stage a: differences
    logic signed [lgi_pkg::DIFF_W-1:0] nd_a, nd_b, nd_c, dd_a, dd_b, dd_c;
    logic [DW-1:0] na_next, nb_next, nc_next, ym_next, fa_next, fb_next, fc_next;
    logic [1:0]    m_next;
    logic          neg_next;

    logic          va_reg;
    logic [DW-1:0] na_reg, nb_reg, nc_reg, ym_reg, fa_reg, fb_reg, fc_reg;
    logic [1:0]    ma_reg;
    logic          nega_reg;

    // stage b and c: products
    logic                       vb_reg, vc_reg;
    logic [lgi_pkg::PROD_W-1:0] nab_reg, ncy_reg, fab_reg;
    logic [DW-1:0]              fcb_reg;
    logic [1:0]                 mb_reg, mc_reg;
    logic                       negb_reg, negc_reg;
    logic [lgi_pkg::P_W-1:0]    p_reg;
    logic [lgi_pkg::DM_W-1:0]   dm_reg;

    // stage d: divider setup
    logic [lgi_pkg::NUM_W-1:0] num_d;
    logic [lgi_pkg::REM_W-1:0] e_d;
    lgi_pkg::div_t             setup_next;
    lgi_pkg::div_t             setup_reg;
    logic                      vd_reg;

    lgi_pkg::div_t chain [0:lgi_pkg::QUO_W];
    logic          vchain [0:lgi_pkg::QUO_W];

    // rounding
    logic                     up;
    logic [lgi_pkg::TERM_W-1:0] q_round;
    logic [lgi_pkg::TERM_W-1:0] mag;
    logic                     cap_next;
    logic                     vr_reg;
    logic signed [lgi_pkg::TERM_W-1:0] term_reg;
    logic                     cap_reg;

    function automatic logic [DW-1:0] mag17(input logic signed [lgi_pkg::DIFF_W-1:0] d);
        logic signed [lgi_pkg::DIFF_W-1:0] a;
        a = (d < 0) ? -d : d;
        return a[DW-1:0];
    endfunction

    always_comb
    begin
        nd_a = DIFF_W'(query_x) - DIFF_W'(xa);
        nd_b = DIFF_W'(query_x) - DIFF_W'(xb);
        nd_c = DIFF_W'(query_x) - DIFF_W'(xc);
        dd_a = DIFF_W'(xi) - DIFF_W'(xa);
        dd_b = DIFF_W'(xi) - DIFF_W'(xb);
        dd_c = DIFF_W'(xi) - DIFF_W'(xc);
        na_next = mag17(nd_a);
        nb_next = mag17(nd_b);
        nc_next = mag17(nd_c);
        ym_next = mag17(DIFF_W'(yi));
        fa_next = (dd_a == 0) ? DW'(1) : mag17(dd_a);
        fb_next = (dd_b == 0) ? DW'(1) : mag17(dd_b);
        fc_next = (dd_c == 0) ? DW'(1) : mag17(dd_c);
        m_next = 2'((dd_a != 0)) + 2'((dd_b != 0)) + 2'((dd_c != 0));
        neg_next = yi[DW-1] ^ nd_a[DW] ^ nd_b[DW] ^ nd_c[DW]
                 ^ dd_a[DW] ^ dd_b[DW] ^ dd_c[DW];
    end

    always_comb
    begin
        if (mc_reg == 2'd3)
        begin
            num_d = {p_reg, 8'd0};
            e_d = dm_reg;
        end
        else
        begin
            num_d = {8'd0, p_reg};
            case (mc_reg)
                2'd0:    e_d = {dm_reg[lgi_pkg::DM_W-17:0], 16'd0};
                2'd1:    e_d = {dm_reg[lgi_pkg::DM_W-9:0], 8'd0};
                default: e_d = dm_reg;
            endcase
        end
        setup_next.rem = lgi_pkg::REM_W'(num_d[lgi_pkg::NUM_W-1:lgi_pkg::QUO_W]);
        setup_next.low = num_d[lgi_pkg::QUO_W-1:0];
        setup_next.quo = '0;
        setup_next.dvs = e_d;
        setup_next.ovf = (lgi_pkg::REM_W'(num_d[lgi_pkg::NUM_W-1:lgi_pkg::QUO_W]) >= e_d);
        setup_next.neg = negc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            vr_reg <= 1'b0;
        end
        else
        begin
            va_reg <= valid_in;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            vr_reg <= vchain[lgi_pkg::QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        na_reg   <= na_next;
        nb_reg   <= nb_next;
        nc_reg   <= nc_next;
        ym_reg   <= ym_next;
        fa_reg   <= fa_next;
        fb_reg   <= fb_next;
        fc_reg   <= fc_next;
        ma_reg   <= m_next;
        nega_reg <= neg_next;

        nab_reg  <= na_reg * nb_reg;
        ncy_reg  <= nc_reg * ym_reg;
        fab_reg  <= fa_reg * fb_reg;
        fcb_reg  <= fc_reg;
        mb_reg   <= ma_reg;
        negb_reg <= nega_reg;

        p_reg    <= nab_reg * ncy_reg;
        dm_reg   <= fab_reg * fcb_reg;
        mc_reg   <= mb_reg;
        negc_reg <= negb_reg;

        setup_reg <= setup_next;
        term_reg  <= (chain[lgi_pkg::QUO_W].neg) ? -$signed(mag) : $signed(mag);
        cap_reg   <= cap_next;
    end

    assign chain[0]  = setup_reg;
    assign vchain[0] = vd_reg;

    genvar g;
    generate
        for (g = 0; g < lgi_pkg::QUO_W; g++)
        begin : g_cell
            lgi_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .valid_in  (vchain[g]),
                .data_in   (chain[g]),
                .valid_out (vchain[g+1]),
                .data_out  (chain[g+1])
            );
        end
    endgenerate

    always_comb
    begin
        up = ({chain[lgi_pkg::QUO_W].rem, 1'b0} >= {1'b0, chain[lgi_pkg::QUO_W].dvs});
        q_round = {1'b0, chain[lgi_pkg::QUO_W].quo} + lgi_pkg::TERM_W'(up);
        cap_next = chain[lgi_pkg::QUO_W].ovf || (q_round > lgi_pkg::TERM_CAP);
        mag = cap_next ? lgi_pkg::TERM_CAP : q_round;
    end

    assign valid_out = vr_reg;
    assign term      = term_reg;
    assign capped    = cap_reg;

endmodule

### sv/lagrange_interpolator_4pt.sv
`timescale 1ns / 1ps
// top level of the four-point lagrange interpolator
//
//  channel   signals                          direction
//  query     start, busy, query_x             in (busy out)
//  result    done, interp_value, saturated    out
//  config    cfg_we, cfg_index, cfg_data      in
//
// one query per cycle; each result appears on done in the order of its query
// the path runs through the 41-cell division chain of each term plus 7 other register stages
// reset returns nodes to x = 0, 256, 512, 768 and y = 0; busy stays low
// results are strobed on done for one cycle and cannot be held off
module lagrange_interpolator_4pt
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    output logic                                     busy,
    input  logic signed [lgi_pkg::DATA_W-1:0]        query_x,
    output logic                                     done,
    output logic signed [lgi_pkg::OUT_W-1:0]         interp_value,
    output logic                                     saturated,
    input  logic                                     cfg_we,
    input  logic [lgi_pkg::IDX_W-1:0]                cfg_index,
    input  logic [lgi_pkg::DATA_W-1:0]               cfg_data
);

    localparam int DW = lgi_pkg::DATA_W;

    logic signed [DW-1:0] x_reg [0:3];
    logic signed [DW-1:0] y_reg [0:3];

    logic                               accept;
    logic                               tv [0:3];
    logic signed [lgi_pkg::TERM_W-1:0]  tt [0:3];
    logic                               tc [0:3];

    logic                               v1_reg;
    logic signed [lgi_pkg::TERM_W:0]    s01_reg, s23_reg;
    logic                               f1_reg;
    logic signed [lgi_pkg::SUM_W-1:0]   sum;

    logic                               done_reg;
    logic signed [lgi_pkg::OUT_W-1:0]   value_reg, value_next;
    logic                               sat_reg, sat_next;

    localparam logic signed [lgi_pkg::SUM_W-1:0] SAT_MAX =
        lgi_pkg::SUM_W'({1'b0, {(lgi_pkg::OUT_W-1){1'b1}}});
    localparam logic signed [lgi_pkg::SUM_W-1:0] SAT_MIN = -SAT_MAX - 1;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg[0] <= 16'sd0;
            x_reg[1] <= 16'sd256;
            x_reg[2] <= 16'sd512;
            x_reg[3] <= 16'sd768;
            y_reg[0] <= 16'sd0;
            y_reg[1] <= 16'sd0;
            y_reg[2] <= 16'sd0;
            y_reg[3] <= 16'sd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lgi_pkg::REG_NODE_X0: x_reg[0] <= cfg_data;
                lgi_pkg::REG_NODE_X1: x_reg[1] <= cfg_data;
                lgi_pkg::REG_NODE_X2: x_reg[2] <= cfg_data;
                lgi_pkg::REG_NODE_X3: x_reg[3] <= cfg_data;
                lgi_pkg::REG_NODE_Y0: y_reg[0] <= cfg_data;
                lgi_pkg::REG_NODE_Y1: y_reg[1] <= cfg_data;
                lgi_pkg::REG_NODE_Y2: y_reg[2] <= cfg_data;
                lgi_pkg::REG_NODE_Y3: y_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    lgi_term u_term0
    (
        .clk (clk), .rst_n (rst_n), .valid_in (accept), .query_x (query_x),
        .xi (x_reg[0]), .xa (x_reg[1]), .xb (x_reg[2]), .xc (x_reg[3]),
        .yi (y_reg[0]), .valid_out (tv[0]), .term (tt[0]), .capped (tc[0])
    );

    lgi_term u_term1
    (
        .clk (clk), .rst_n (rst_n), .valid_in (accept), .query_x (query_x),
        .xi (x_reg[1]), .xa (x_reg[0]), .xb (x_reg[2]), .xc (x_reg[3]),
        .yi (y_reg[1]), .valid_out (tv[1]), .term (tt[1]), .capped (tc[1])
    );

    lgi_term u_term2
    (
        .clk (clk), .rst_n (rst_n), .valid_in (accept), .query_x (query_x),
        .xi (x_reg[2]), .xa (x_reg[0]), .xb (x_reg[1]), .xc (x_reg[3]),
        .yi (y_reg[2]), .valid_out (tv[2]), .term (tt[2]), .capped (tc[2])
    );

    lgi_term u_term3
    (
        .clk (clk), .rst_n (rst_n), .valid_in (accept), .query_x (query_x),
        .xi (x_reg[3]), .xa (x_reg[0]), .xb (x_reg[1]), .xc (x_reg[2]),
        .yi (y_reg[3]), .valid_out (tv[3]), .term (tt[3]), .capped (tc[3])
    );

    always_comb
    begin
        sum = lgi_pkg::SUM_W'(s01_reg) + lgi_pkg::SUM_W'(s23_reg);
        sat_next = f1_reg;
        value_next = sum[lgi_pkg::OUT_W-1:0];
        if (sum > SAT_MAX)
        begin
            value_next = SAT_MAX[lgi_pkg::OUT_W-1:0];
            sat_next = 1'b1;
        end
        else if (sum < SAT_MIN)
        begin
            value_next = SAT_MIN[lgi_pkg::OUT_W-1:0];
            sat_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= tv[0] & tv[1] & tv[2] & tv[3];
            done_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s01_reg   <= (lgi_pkg::TERM_W+1)'(tt[0]) + (lgi_pkg::TERM_W+1)'(tt[1]);
        s23_reg   <= (lgi_pkg::TERM_W+1)'(tt[2]) + (lgi_pkg::TERM_W+1)'(tt[3]);
        f1_reg    <= tc[0] | tc[1] | tc[2] | tc[3];
        value_reg <= value_next;
        sat_reg   <= sat_next;
    end

    assign done         = done_reg;
    assign interp_value = value_reg;
    assign saturated    = sat_reg;

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the four-point lagrange interpolator
module tb;

    localparam int DATA_W  = lgi_pkg::DATA_W;
    localparam int OUT_W   = lgi_pkg::OUT_W;
    localparam int IDX_W   = lgi_pkg::IDX_W;
    localparam int LIMIT   = 400000;
    localparam int PHASES  = 10;
    localparam int PER_SET = 110;

    typedef struct {
        logic signed [OUT_W-1:0] value;
        logic                    sat;
    } interp_result_t;

    typedef struct {
        bit                       is_cfg;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] data;
        bit                       typed;
        logic signed [OUT_W-1:0]  val;
        logic                     sat;
    } step_row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [DATA_W-1:0] query_x;
    logic done;
    logic signed [OUT_W-1:0] interp_value;
    logic saturated;
    logic cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0] cfg_data;

    logic signed [DATA_W-1:0] node_x [4];
    logic signed [DATA_W-1:0] node_y [4];
    interp_result_t pending_results [$];
    int errors;
    int cycles;
    int queries_sent;
    int results_seen;
    int sat_seen;
    bit no_idle;

    lagrange_interpolator_4pt uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .query_x      (query_x),
        .done         (done),
        .interp_value (interp_value),
        .saturated    (saturated),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // evaluation of the cubic through the current nodes, rounded, with term cap and saturation
    function automatic interp_result_t lagrange_eval(input logic signed [DATA_W-1:0] qx);
        interp_result_t res;
        longint unsigned cap;
        longint unsigned nmag;
        longint unsigned dmag;
        longint unsigned p;
        longint unsigned e;
        longint unsigned mg;
        longint unsigned q1;
        longint unsigned r1;
        longint unsigned rs;
        longint unsigned r2;
        longint sum;
        longint d;
        int m;
        int t;
        bit neg;
        bit flag;
        cap = 64'd1 << 40;
        sum = 0;
        flag = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            nmag = 1;
            dmag = 1;
            m = 0;
            neg = node_y[i] < 0;
            for (int k = 0; k < 4; k++)
            begin
                if (k != i)
                begin
                    d = longint'(qx) - longint'(node_x[k]);
                    nmag = nmag * longint'(d < 0 ? -d : d);
                    if (d < 0)
                        neg = !neg;
                end
            end
            for (int k = 0; k < 4; k++)
            begin
                d = longint'(node_x[i]) - longint'(node_x[k]);
                if (d != 0)
                begin
                    dmag = dmag * longint'(d < 0 ? -d : d);
                    if (d < 0)
                        neg = !neg;
                    m++;
                end
            end
            d = longint'(node_y[i]);
            p = longint'(d < 0 ? -d : d) * nmag;
            if (m == 3)
            begin
                t = 8;
                e = dmag;
            end
            else
            begin
                t = 0;
                e = dmag << (16 - 8 * m);
            end
            q1 = p / e;
            r1 = p % e;
            if (q1 > (cap >> t))
            begin
                flag = 1'b1;
                mg = cap;
            end
            else
            begin
                rs = r1 << t;
                mg = (q1 << t) + rs / e;
                r2 = rs % e;
                if (r2 >= e - r2)
                    mg++;
                if (mg > cap)
                begin
                    flag = 1'b1;
                    mg = cap;
                end
            end
            sum = neg ? sum - longint'(mg) : sum + longint'(mg);
        end
        if (sum > 64'sd2147483647)
        begin
            sum = 64'sd2147483647;
            flag = 1'b1;
        end
        else if (sum < -64'sd2147483648)
        begin
            sum = -64'sd2147483648;
            flag = 1'b1;
        end
        res.value = sum[31:0];
        res.sat = flag;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic signed [DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx < lgi_pkg::REG_NODE_Y0)
            node_x[idx[1:0]] = data;
        else
            node_y[idx[1:0]] = data;
        @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic send_query(input logic signed [DATA_W-1:0] x, input bit typed,
                              input logic signed [OUT_W-1:0] tv, input logic ts);
        interp_result_t res;
        int gap;
        start <= 1'b1;
        query_x <= x;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (typed)
        begin
            res.value = tv;
            res.sat = ts;
        end
        else
            res = lagrange_eval(x);
        pending_results.push_back(res);
        queries_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic signed [DATA_W-1:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'sd0;
            3: return -16'sd1;
            default: return 16'sd1;
        endcase
    endfunction

    task automatic random_config();
        logic signed [DATA_W-1:0] base;
        logic signed [DATA_W-1:0] step;
        int shape;
        shape = $urandom_range(0, 3);
        base = DATA_W'($urandom);
        step = DATA_W'($urandom_range(1, 512));
        for (int i = 0; i < 4; i++)
        begin
            case (shape)
                0: write_reg(lgi_pkg::REG_NODE_X0 + IDX_W'(i), DATA_W'($urandom));
                1: write_reg(lgi_pkg::REG_NODE_X0 + IDX_W'(i), DATA_W'(base + step * i));
                2: write_reg(lgi_pkg::REG_NODE_X0 + IDX_W'(i),
                             DATA_W'((i < 2) ? base : base + step * i));
                default: write_reg(lgi_pkg::REG_NODE_X0 + IDX_W'(i), pick_extreme());
            endcase
        end
        for (int i = 0; i < 4; i++)
        begin
            if (shape == 3)
                write_reg(lgi_pkg::REG_NODE_Y0 + IDX_W'(i), pick_extreme());
            else
                write_reg(lgi_pkg::REG_NODE_Y0 + IDX_W'(i), DATA_W'($urandom));
        end
    endtask

    // result check against the oldest expected transaction
    always @(posedge clk)
    begin
        interp_result_t exp_res;
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else if (rst_n && done)
        begin
            results_seen++;
            if (saturated)
                sat_seen++;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %0d sat %0d", interp_value, saturated);
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (interp_value !== exp_res.value || saturated !== exp_res.sat)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %0d sat %0d, got %0d sat %0d",
                                 exp_res.value, exp_res.sat, interp_value, saturated);
                end
            end
        end
    end

    initial
    begin
        step_row_t rows [$];
        logic signed [DATA_W-1:0] qx;
        rst_n = 1'b0;
        start = 1'b0;
        query_x = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        cycles = 0;
        queries_sent = 0;
        results_seen = 0;
        sat_seen = 0;
        no_idle = 1'b0;
        node_x[0] = 0;
        node_x[1] = 256;
        node_x[2] = 512;
        node_x[3] = 768;
        for (int i = 0; i < 4; i++)
            node_y[i] = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset nodes with zero values, then exact hits on nodes
        rows.push_back('{0, 0, -16'sd32768, 1, 0, 0});
        rows.push_back('{0, 0, 16'sd32767, 1, 0, 0});
        rows.push_back('{0, 0, 16'sd0, 1, 0, 0});
        rows.push_back('{1, lgi_pkg::REG_NODE_Y0, 16'sd256, 0, 0, 0});
        rows.push_back('{0, 0, 16'sd0, 1, 65536, 0});
        rows.push_back('{0, 0, 16'sd256, 1, 0, 0});
        rows.push_back('{0, 0, 16'sd512, 1, 0, 0});
        rows.push_back('{1, lgi_pkg::REG_NODE_Y1, -16'sd32768, 0, 0, 0});
        rows.push_back('{0, 0, 16'sd256, 1, -8388608, 0});
        rows.push_back('{1, lgi_pkg::REG_NODE_Y2, 16'sd32767, 0, 0, 0});
        rows.push_back('{0, 0, 16'sd512, 1, 8388352, 0});
        // outer nodes at the extremes, large values far out
        rows.push_back('{1, lgi_pkg::REG_NODE_X0, -16'sd32768, 0, 0, 0});
        rows.push_back('{1, lgi_pkg::REG_NODE_X3, 16'sd32767, 0, 0, 0});
        rows.push_back('{0, 0, -16'sd32768, 0, 0, 0});
        rows.push_back('{0, 0, 16'sd32767, 0, 0, 0});
        rows.push_back('{0, 0, 16'sd1000, 0, 0, 0});
        rows.push_back('{1, lgi_pkg::REG_NODE_Y3, -16'sd32768, 0, 0, 0});
        rows.push_back('{0, 0, -16'sd20000, 0, 0, 0});
        rows.push_back('{0, 0, 16'sd32767, 0, 0, 0});
        // all nodes coincident
        rows.push_back('{1, lgi_pkg::REG_NODE_X1, -16'sd32768, 0, 0, 0});
        rows.push_back('{1, lgi_pkg::REG_NODE_X2, -16'sd32768, 0, 0, 0});
        rows.push_back('{1, lgi_pkg::REG_NODE_X3, -16'sd32768, 0, 0, 0});
        rows.push_back('{0, 0, 16'sd100, 0, 0, 0});
        rows.push_back('{0, 0, 16'sd32767, 0, 0, 0});
        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
            begin
                drain();
                write_reg(rows[i].idx, rows[i].data);
            end
            else
                send_query(rows[i].data, rows[i].typed, rows[i].val, rows[i].sat);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            random_config();
            no_idle = (ph % 3 == 0);
            for (int n = 0; n < PER_SET; n++)
            begin
                if ($urandom_range(0, 9) < 7)
                    qx = DATA_W'($urandom);
                else
                    qx = DATA_W'(node_x[$urandom_range(0, 3)]
                                 + $signed($urandom_range(0, 8)) - 4);
                send_query(qx, 0, 0, 0);
            end
        end

        drain();
        repeat (60) @(posedge clk);
        $display("%0d query transactions over %0d node settings, %0d results, %0d saturated",
                 queries_sent, PHASES + 1, results_seen, sat_seen);
        if (errors == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
        begin
            $display("%0d mismatches, %0d results missing", errors, pending_results.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
